/* hw/rtl/bptc_pkg.sv */
// Shared types and constants for the barometric pressure and temperature
// compensation core: register map codes and result limits.
// No dependencies.
package bptc_pkg;

    // Calibration register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFF_BASE    = 3'd1,
        REG_SENS_TCOEF  = 3'd2,
        REG_OFF_TCOEF   = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SENS   = 3'd5
    } t_reg_idx;

    // Temperature in hundredths of a degree Celsius.
    localparam int TEMP_MIN       = -4000;
    localparam int TEMP_MAX       = 8500;
    // 20.00 degC, the threshold of the second-order correction.
    localparam int TEMP_REF       = 2000;
    // Distance from the extra-correction threshold (-15.00 degC) to TEMP_REF.
    localparam int TEMP_LOW_OFS   = 3500;

    // Pressure in hundredths of a millibar.
    localparam int PRES_MIN       = 1000;
    localparam int PRES_MAX       = 120000;

endpackage

/* hw/rtl/baro_pressure_temp_compensation_core.sv */
// Top level of the barometric pressure and temperature compensation core.
// Depends on bptc_pkg for register codes and result limits.
//
// The core takes one raw pressure and one raw temperature conversion per
// transfer and returns the compensated temperature (0.01 degC) and pressure
// (0.01 mbar), both saturated to the sensor range, with a flag that reports
// saturation. The second-order correction below 20.00 degC and the extra
// correction below -15.00 degC are applied. The datapath is a ten-stage
// pipeline: a transfer can be accepted in every cycle while the output side
// keeps taking results, and its result is presented from the last stage.
// Each stage holds its own valid bit, so a stall on the output only holds
// the occupied stages and empty stages keep filling. The widest
// multiplication (raw pressure times sensitivity) is split into two partial
// products in one stage and summed in the next. The six calibration words
// are written through the APB-style port and must be stable while transfers
// are in flight.
module baro_pressure_temp_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [23:0]        i_pressure_raw,
    input  logic [23:0]        i_temperature_raw,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_temperature_centi,
    output logic [16:0]        o_pressure_centi,
    output logic               o_out_of_range,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bptc_pkg::*;

    localparam int NSTG = 10;

    // Calibration words.
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // Pipeline control.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // Stage 1: difference to the reference temperature.
    logic signed [24:0] r_s1_dt;
    logic [23:0]        r_s1_d1;
    // Stage 2: first products.
    logic signed [41:0] r_s2_pt, r_s2_po, r_s2_ps;
    logic signed [49:0] r_s2_pdd;
    logic [23:0]        r_s2_d1;
    // Stage 3: first-order temperature, offset and sensitivity.
    logic signed [18:0] w_s3_a;
    logic signed [19:0] w_s3_temp, w_s3_b;
    logic signed [36:0] w_s3_off;
    logic signed [35:0] w_s3_sens;
    logic signed [18:0] r_s3_a;
    logic signed [19:0] r_s3_temp, r_s3_b;
    logic signed [36:0] r_s3_off;
    logic signed [35:0] r_s3_sens;
    logic [16:0]        r_s3_t2;
    logic [23:0]        r_s3_d1;
    // Stage 4: squares for the second-order terms.
    logic signed [37:0] r_s4_sq;
    logic signed [39:0] r_s4_sq2;
    logic signed [19:0] r_s4_temp;
    logic signed [36:0] r_s4_off;
    logic signed [35:0] r_s4_sens;
    logic [16:0]        r_s4_t2;
    logic [23:0]        r_s4_d1;
    logic               r_s4_lt_ref, r_s4_lt_low;
    // Stage 5: correction terms.
    logic [35:0]        w_s5_sq, w_s5_sq2;
    logic [38:0]        w_s5_sq5, w_s5_sq7;
    logic [39:0]        w_s5_sq11;
    logic [39:0]        w_s5_off2;
    logic [38:0]        w_s5_sens2;
    logic signed [20:0] w_s5_temp;
    logic [39:0]        r_s5_off2;
    logic [38:0]        r_s5_sens2;
    logic signed [20:0] r_s5_temp;
    logic signed [36:0] r_s5_off;
    logic signed [35:0] r_s5_sens;
    logic [23:0]        r_s5_d1;
    // Stage 6: corrected offset and sensitivity.
    logic signed [39:0] r_s6_off;
    logic signed [38:0] r_s6_sens;
    logic signed [20:0] r_s6_temp;
    logic [23:0]        r_s6_d1;
    // Stage 7: partial products of pressure times sensitivity.
    logic [43:0]        r_s7_lo;
    logic signed [43:0] r_s7_hi;
    logic signed [39:0] r_s7_off;
    logic signed [20:0] r_s7_temp;
    // Stage 8: full product.
    logic signed [63:0] r_s8_prod;
    logic signed [39:0] r_s8_off;
    logic signed [20:0] r_s8_temp;
    // Stage 9: raw pressure.
    logic signed [42:0] w_s9_diff;
    logic signed [27:0] r_s9_pres;
    logic signed [20:0] r_s9_temp;
    // Stage 10: saturated result.
    logic signed [14:0] r_out_temp;
    logic [16:0]        r_out_pres;
    logic               r_out_oor;

    logic w_cfg_wr;

    // Configuration writes and reads; writes beyond the map are dropped.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_SENS_BASE:  r_c1 <= pwdata[15:0];
                REG_OFF_BASE:   r_c2 <= pwdata[15:0];
                REG_SENS_TCOEF: r_c3 <= pwdata[15:0];
                REG_OFF_TCOEF:  r_c4 <= pwdata[15:0];
                REG_REF_TEMP:   r_c5 <= pwdata[15:0];
                REG_TEMP_SENS:  r_c6 <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_SENS_BASE:  prdata = {16'b0, r_c1};
            REG_OFF_BASE:   prdata = {16'b0, r_c2};
            REG_SENS_TCOEF: prdata = {16'b0, r_c3};
            REG_OFF_TCOEF:  prdata = {16'b0, r_c4};
            REG_REF_TEMP:   prdata = {16'b0, r_c5};
            REG_TEMP_SENS:  prdata = {16'b0, r_c6};
            default:        prdata = '0;
        endcase
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage 1: dT = D2 - C5 * 256.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_dt <= $signed({1'b0, i_temperature_raw}) - $signed({1'b0, r_c5, 8'b0});
            r_s1_d1 <= i_pressure_raw;
        end
    end

    // Stage 2: products of dT with the temperature coefficients and itself.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_pt  <= r_s1_dt * $signed({1'b0, r_c6});
            r_s2_po  <= r_s1_dt * $signed({1'b0, r_c4});
            r_s2_ps  <= r_s1_dt * $signed({1'b0, r_c3});
            r_s2_pdd <= r_s1_dt * r_s1_dt;
            r_s2_d1  <= r_s1_d1;
        end
    end

    // Stage 3: the shifted products give TEMP - 2000, OFF and SENS.
    assign w_s3_a    = $signed(r_s2_pt[41:23]);
    assign w_s3_temp = $signed({w_s3_a[18], w_s3_a}) + $signed(20'(TEMP_REF));
    assign w_s3_b    = $signed({w_s3_a[18], w_s3_a}) + $signed(20'(TEMP_LOW_OFS));
    assign w_s3_off  = $signed({5'b0, r_c2, 16'b0})
                     + $signed({{2{r_s2_po[41]}}, r_s2_po[41:7]});
    assign w_s3_sens = $signed({5'b0, r_c1, 15'b0})
                     + $signed({{2{r_s2_ps[41]}}, r_s2_ps[41:8]});

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_a    <= w_s3_a;
            r_s3_temp <= w_s3_temp;
            r_s3_b    <= w_s3_b;
            r_s3_off  <= w_s3_off;
            r_s3_sens <= w_s3_sens;
            // dT squared is below 2^48, so bits 47 to 31 hold the shifted value.
            r_s3_t2   <= r_s2_pdd[47:31];
            r_s3_d1   <= r_s2_d1;
        end
    end

    // Stage 4: squares of the distances to both thresholds.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_sq     <= r_s3_a * r_s3_a;
            r_s4_sq2    <= r_s3_b * r_s3_b;
            r_s4_temp   <= r_s3_temp;
            r_s4_off    <= r_s3_off;
            r_s4_sens   <= r_s3_sens;
            r_s4_t2     <= r_s3_t2;
            r_s4_d1     <= r_s3_d1;
            r_s4_lt_ref <= r_s3_a[18];
            r_s4_lt_low <= r_s3_b[19];
        end
    end

    // Stage 5: second-order terms, zero at or above 20.00 degC.
    // Both squares stay below 2^36 wherever they are used.
    assign w_s5_sq   = r_s4_sq[35:0];
    assign w_s5_sq2  = r_s4_sq2[35:0];
    assign w_s5_sq5  = {3'b0, w_s5_sq} + {1'b0, w_s5_sq, 2'b0};
    assign w_s5_sq7  = {w_s5_sq2, 3'b0} - {3'b0, w_s5_sq2};
    assign w_s5_sq11 = {1'b0, w_s5_sq2, 3'b0} + {3'b0, w_s5_sq2, 1'b0}
                     + {4'b0, w_s5_sq2};

    always_comb begin
        w_s5_off2  = '0;
        w_s5_sens2 = '0;
        if (r_s4_lt_ref) begin
            w_s5_off2  = {2'b0, w_s5_sq5[38:1]};
            w_s5_sens2 = {2'b0, w_s5_sq5[38:2]};
            if (r_s4_lt_low) begin
                w_s5_off2  = w_s5_off2 + {1'b0, w_s5_sq7};
                w_s5_sens2 = w_s5_sens2 + w_s5_sq11[39:1];
            end
        end
    end

    assign w_s5_temp = $signed({r_s4_temp[19], r_s4_temp})
                     - $signed({4'b0, (r_s4_lt_ref ? r_s4_t2 : 17'd0)});

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_off2  <= w_s5_off2;
            r_s5_sens2 <= w_s5_sens2;
            r_s5_temp  <= w_s5_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_d1    <= r_s4_d1;
        end
    end

    // Stage 6: OFF - OFF2 and SENS - SENS2; both corrections stay below 2^38.
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_off  <= $signed({{3{r_s5_off[36]}}, r_s5_off}) - $signed(r_s5_off2);
            r_s6_sens <= $signed({{3{r_s5_sens[35]}}, r_s5_sens}) - $signed(r_s5_sens2);
            r_s6_temp <= r_s5_temp;
            r_s6_d1   <= r_s5_d1;
        end
    end

    // Stage 7: D1 * SENS split into a low unsigned and a high signed part.
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_lo   <= {20'b0, r_s6_d1} * {24'b0, r_s6_sens[19:0]};
            r_s7_hi   <= $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[38:20]);
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
        end
    end

    // Stage 8: sum of the partial products.
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_prod <= $signed({r_s7_hi, 20'b0}) + $signed({20'b0, r_s7_lo});
            r_s8_off  <= r_s7_off;
            r_s8_temp <= r_s7_temp;
        end
    end

    // Stage 9: P = ((D1 * SENS >> 21) - OFF) >> 15.
    assign w_s9_diff = $signed(r_s8_prod[63:21]) - $signed({{3{r_s8_off[39]}}, r_s8_off});

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s9_pres <= w_s9_diff[42:15];
            r_s9_temp <= r_s8_temp;
        end
    end

    // Stage 10: saturate both results and flag any clamping.
    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_out_oor <= (r_s9_temp < TEMP_MIN) || (r_s9_temp > TEMP_MAX)
                      || (r_s9_pres < PRES_MIN) || (r_s9_pres > PRES_MAX);
            if (r_s9_temp < TEMP_MIN) begin
                r_out_temp <= 15'(TEMP_MIN);
            end else if (r_s9_temp > TEMP_MAX) begin
                r_out_temp <= 15'(TEMP_MAX);
            end else begin
                r_out_temp <= r_s9_temp[14:0];
            end
            if (r_s9_pres < PRES_MIN) begin
                r_out_pres <= 17'(PRES_MIN);
            end else if (r_s9_pres > PRES_MAX) begin
                r_out_pres <= 17'(PRES_MAX);
            end else begin
                r_out_pres <= r_s9_pres[16:0];
            end
        end
    end

    assign o_temperature_centi = r_out_temp;
    assign o_pressure_centi    = r_out_pres;
    assign o_out_of_range      = r_out_oor;

`ifndef SYNTHESIS
    // A presented temperature always lies within the sensor range.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature_centi >= TEMP_MIN)
                     && (o_temperature_centi <= TEMP_MAX))
        else $error("temperature result outside its range");

    // A presented pressure always lies within the sensor range.
    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressure_centi >= 17'(PRES_MIN))
                     && (o_pressure_centi <= 17'(PRES_MAX)))
        else $error("pressure result outside its range");

    // The flag can only be set when a result sits at one of its limits.
    a_flag_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_temperature_centi != TEMP_MIN)
         && (o_temperature_centi != TEMP_MAX)
         && (o_pressure_centi != 17'(PRES_MIN))
         && (o_pressure_centi != 17'(PRES_MAX))) |-> !o_out_of_range)
        else $error("range flag set on an unclamped result");

    // Input back-pressure only occurs when every stage holds a transfer.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ($countones(r_vld) == NSTG))
        else $error("input stalled while the pipeline has a free stage");
`endif

endmodule

/* tb/baro_pressure_temp_compensation_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the barometric pressure and temperature compensation core.
// Depends on bptc_pkg and baro_pressure_temp_compensation_core; drives both channels and
// the calibration port and checks every result against an in-bench compensation predictor.
module baro_pressure_temp_compensation_core_tb;
    import bptc_pkg::*;

    localparam int     NUM_CAL_REGS    = 6;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     ITEMS_PER_PHASE = 50;
    localparam int     DRAIN_CYCLES    = 20;
    localparam int     CYCLE_LIMIT     = 200000;
    localparam int     MAX_REPORTS     = 10;
    localparam int     MAX_GAP         = 16;
    localparam longint RAW_MAX         = (64'sd1 <<< 24) - 1;
    // Temperature below which the extra low-temperature correction applies.
    localparam int     TEMP_LOW        = TEMP_REF - TEMP_LOW_OFS;

    // Calibration words of a typical sensor, used as a realistic starting point.
    localparam logic [15:0] TYPICAL_CAL [NUM_CAL_REGS] =
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

    typedef enum int {
        CAL_NEAR_TYPICAL,
        CAL_UNIFORM,
        CAL_EXTREME
    } t_cal_style;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [16:0]        pres;
        logic               oor;
    } t_reading;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [23:0]        i_pressure_raw;
    logic [23:0]        i_temperature_raw;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [14:0] o_temperature_centi;
    logic [16:0]        o_pressure_centi;
    logic               o_out_of_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state: the calibration words as the core should hold them.
    logic [15:0] cal_words [NUM_CAL_REGS];
    t_reading    pending_readings [$];

    int  error_count;
    int  cycle_count;
    int  inputs_sent;
    int  results_checked;
    int  saturated_results;
    int  settings_used;
    bit  in_gaps_on;
    bit  out_gaps_on;
    bit  out_taken;
    int  out_hold;

    baro_pressure_temp_compensation_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_pressure_raw      (i_pressure_raw),
        .i_temperature_raw   (i_temperature_raw),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_centi    (o_pressure_centi),
        .o_out_of_range      (o_out_of_range),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit; a hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                     pending_readings.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Second-order compensation of one raw pressure and temperature pair.
    function automatic t_reading compensate_reading(input logic [23:0] p_raw,
                                                    input logic [23:0] t_raw);
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, off, sens, t2, off2, sens2, pres, a, b;
        t_reading r;
        d1 = p_raw;
        d2 = t_raw;
        c1 = cal_words[REG_SENS_BASE];
        c2 = cal_words[REG_OFF_BASE];
        c3 = cal_words[REG_SENS_TCOEF];
        c4 = cal_words[REG_OFF_TCOEF];
        c5 = cal_words[REG_REF_TEMP];
        c6 = cal_words[REG_TEMP_SENS];
        r.oor = 1'b0;

        dt   = d2 - c5 * 256;
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
        sens = (c1 <<< 15) + ((c3 * dt) >>> 8);

        // Corrections below 20.00 degC, with an extra term below -15.00 degC.
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < TEMP_REF) begin
            a     = temp - TEMP_REF;
            t2    = (dt * dt) >>> 31;
            off2  = (5 * a * a) >>> 1;
            sens2 = (5 * a * a) >>> 2;
            if (temp < TEMP_LOW) begin
                b     = temp - TEMP_LOW;
                off2  = off2 + 7 * b * b;
                sens2 = sens2 + ((11 * b * b) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        pres = (((d1 * sens) >>> 21) - off) >>> 15;

        // Saturate both results to the sensor range.
        if (temp < TEMP_MIN) begin
            temp  = TEMP_MIN;
            r.oor = 1'b1;
        end else if (temp > TEMP_MAX) begin
            temp  = TEMP_MAX;
            r.oor = 1'b1;
        end
        if (pres < PRES_MIN) begin
            pres  = PRES_MIN;
            r.oor = 1'b1;
        end else if (pres > PRES_MAX) begin
            pres  = PRES_MAX;
            r.oor = 1'b1;
        end
        r.temp = temp[14:0];
        r.pres = pres[16:0];
        return r;
    endfunction

    // Raw temperature that lands near a target temperature under the current calibration.
    function automatic logic [23:0] raw_for_temp(input int target);
        longint c5, c6, dt, d2;
        c5 = cal_words[REG_REF_TEMP];
        c6 = cal_words[REG_TEMP_SENS];
        dt = (c6 == 0) ? 0 : (longint'(target - TEMP_REF) <<< 23) / c6;
        d2 = c5 * 256 + dt;
        if (d2 < 0)
            d2 = 0;
        else if (d2 > RAW_MAX)
            d2 = RAW_MAX;
        return d2[23:0];
    endfunction

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(MAX_GAP, 0)) : 0;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
            report_error($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    // Result checker: every output transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_taken = 1'b1;
            if (pending_readings.size() == 0) begin
                report_error("result transfer with no prediction pending");
            end else begin
                want = pending_readings.pop_front();
                check_field("temperature", want.temp, o_temperature_centi);
                check_field("pressure", want.pres, o_pressure_centi);
                check_field("out_of_range", want.oor, o_out_of_range);
                if (want.oor)
                    saturated_results++;
                results_checked++;
            end
        end
    end

    // Output back-pressure: after each result transfer, hold ready low for a random stall.
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_hold  = draw_gap(out_gaps_on);
            out_taken = 1'b0;
        end
        if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one raw pair and record its prediction once the transfer happens.
    task automatic send_reading(input logic [23:0] p_raw, input logic [23:0] t_raw);
        int gap;
        gap = draw_gap(in_gaps_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_pressure_raw    <= p_raw;
        i_temperature_raw <= t_raw;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(compensate_reading(p_raw, t_raw));
        inputs_sent++;
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register updates at the access edge.
    task automatic cal_write(input int index, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(index * 4);
        pwdata  <= {16'h0000, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index < NUM_CAL_REGS)
            cal_words[index] = value;
    endtask

    task automatic cal_read(input int index, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(index * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_cal_readback();
        logic [31:0] data;
        for (int i = 0; i < NUM_CAL_REGS; i++) begin
            cal_read(i, data);
            if (data !== {16'h0000, cal_words[i]})
                report_error($sformatf("register %0d read back %0h, expected %0h",
                                       i, data, cal_words[i]));
        end
    endtask

    task automatic load_cal(input logic [15:0] words [NUM_CAL_REGS]);
        for (int i = 0; i < NUM_CAL_REGS; i++)
            cal_write(i, words[i]);
        check_cal_readback();
        settings_used++;
    endtask

    task automatic draw_cal(input t_cal_style style, output logic [15:0] words [NUM_CAL_REGS]);
        int v;
        for (int i = 0; i < NUM_CAL_REGS; i++) begin
            case (style)
                CAL_NEAR_TYPICAL: begin
                    v = int'(TYPICAL_CAL[i]) + int'($urandom_range(8191, 0)) - 4096;
                    if (v < 0)
                        v = 0;
                    else if (v > 65535)
                        v = 65535;
                    words[i] = v[15:0];
                end
                CAL_UNIFORM: begin
                    words[i] = 16'($urandom_range(65535, 0));
                end
                default: begin
                    words[i] = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
                end
            endcase
        end
    endtask

    // Straight after reset every calibration word is zero; the pressure results saturate.
    task automatic test_reset_defaults();
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'hFFFFFF, 24'h000000);
        wait_for_drain();
        check_cal_readback();
    endtask

    // Typical calibration: both correction regions, their thresholds and every clamp.
    task automatic test_typical_calibration();
        load_cal(TYPICAL_CAL);
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'd9085466, 24'(cal_words[REG_REF_TEMP] * 256));
        send_reading(24'd9085466, raw_for_temp(TEMP_REF - 1));
        send_reading(24'd9085466, raw_for_temp(TEMP_LOW + 1));
        send_reading(24'd9085466, raw_for_temp(TEMP_LOW - 1));
        send_reading(24'd8000000, raw_for_temp(TEMP_MIN + 100));
        send_reading(24'd9500000, raw_for_temp(TEMP_MAX - 1));
        send_reading(24'd9085466, 24'hFFFFFF);
        send_reading(24'd9085466, 24'h000000);
        send_reading(24'h000000, 24'd8569150);
        send_reading(24'hFFFFFF, 24'd8569150);
        wait_for_drain();
    endtask

    // Writes beyond the last calibration register must leave the map untouched.
    task automatic test_unmapped_registers();
        cal_write(NUM_CAL_REGS, 16'hFFFF);
        cal_write(NUM_CAL_REGS + 1, 16'h0000);
        check_cal_readback();
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'd7000000, raw_for_temp(0));
        wait_for_drain();
    endtask

    // All-ones and all-zero calibration with extreme raw values.
    task automatic test_calibration_extremes();
        logic [15:0] words [NUM_CAL_REGS];
        foreach (words[i]) words[i] = 16'hFFFF;
        load_cal(words);
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'h000000);
        send_reading(24'h000000, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        wait_for_drain();
        foreach (words[i]) words[i] = 16'h0000;
        load_cal(words);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h000000, 24'h800000);
        wait_for_drain();
    endtask

    // Random readings over several calibrations and idle patterns on both channels.
    task automatic test_random_traffic();
        logic [15:0] words [NUM_CAL_REGS];
        logic [23:0] p_raw, t_raw;
        int          target;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            draw_cal(t_cal_style'(ph % 3), words);
            load_cal(words);
            in_gaps_on  = (ph % 4 == 0) || (ph % 4 == 2);
            out_gaps_on = (ph % 4 == 0) || (ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(9, 0) < 6) begin
                    target = int'($urandom_range(15000, 0)) - 6000;
                    t_raw  = raw_for_temp(target);
                end else begin
                    t_raw = 24'($urandom_range(RAW_MAX, 0));
                end
                if ($urandom_range(9, 0) < 6)
                    p_raw = 24'($urandom_range(11000000, 3500000));
                else
                    p_raw = 24'($urandom_range(RAW_MAX, 0));
                send_reading(p_raw, t_raw);
            end
            wait_for_drain();
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_pressure_raw    = '0;
        i_temperature_raw = '0;
        i_out_ready       = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        out_taken         = 1'b0;
        out_hold          = 0;
        in_gaps_on        = 1'b1;
        out_gaps_on       = 1'b1;
        foreach (cal_words[i]) cal_words[i] = 16'h0000;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_typical_calibration();
        test_unmapped_registers();
        test_calibration_extremes();
        test_random_traffic();

        if (pending_readings.size() != 0)
            report_error($sformatf("%0d predicted results never arrived",
                                   pending_readings.size()));
        $display("Run covered %0d input transfers and %0d result transfers under %0d calibrations,",
                 inputs_sent, results_checked, settings_used);
        $display("with %0d saturated results and %0d mismatches.", saturated_results, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* baro_pressure_temp_compensation_core.f */
hw/rtl/bptc_pkg.sv
hw/rtl/baro_pressure_temp_compensation_core.sv
tb/baro_pressure_temp_compensation_core_tb.sv
